// ----- hdl/rxag_pkg.sv -----
// Shared constants, types and helpers for the rotate-xor-add generator.
package rxag_pkg;

  localparam int unsigned WORD_W = 64;

  // Weyl counter increment
  localparam logic [WORD_W-1:0] WEYL_STEP = 64'd111111111111111111;

  // Fixed left-rotate amounts
  localparam int unsigned ROT_MIX = 29;
  localparam int unsigned ROT_ONE = 47;
  localparam int unsigned ROT_TWO = 25;
  localparam int unsigned ROT_OUT = 21;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SEED_MIX       = 2'd0,
    REG_SEED_COUNTER   = 2'd1,
    REG_SEED_ACCUM_ONE = 2'd2,
    REG_SEED_ACCUM_TWO = 2'd3
  } cfg_reg_t;

  // Head of the request queue as seen by the back part
  typedef struct packed {
    logic valid;
    logic reload;
  } rxag_head_t;

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

// ----- hdl/rxag_front.sv -----
// Request front end: accepts transactions and queues their reload flags.
module rxag_front
  import rxag_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       reload,
  output rxag_head_t head,
  input  logic       pop
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             flags [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pull;

  assign in_ready    = (count != CNT_W'(QUEUE_DEPTH));
  assign push        = in_valid && in_ready;
  assign pull        = pop && head.valid;
  assign head.valid  = (count != '0);
  assign head.reload = flags[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      flags[wr_ptr] <= reload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pull) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pull})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/rxag_back.sv -----
// Generator core: seed registers, state recurrence and output mixing stage.
module rxag_back
  import rxag_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  input  rxag_head_t             head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [WORD_W-1:0]      out_word0,
  output logic [WORD_W-1:0]      out_word1,
  output logic [WORD_W-1:0]      out_word2,
  output logic [WORD_W-1:0]      out_word3
);

  logic [WORD_W-1:0] seed_mix;
  logic [WORD_W-1:0] seed_counter;
  logic [WORD_W-1:0] seed_accum_one;
  logic [WORD_W-1:0] seed_accum_two;

  logic [WORD_W-1:0] mix_word;
  logic [WORD_W-1:0] weyl_counter;
  logic [WORD_W-1:0] accum_one;
  logic [WORD_W-1:0] accum_two;

  // Old accumulators of the step whose outputs are still to be mixed
  logic              pend_valid;
  logic [WORD_W-1:0] pend_one;
  logic [WORD_W-1:0] pend_two;

  logic [WORD_W-1:0] base_mix;
  logic [WORD_W-1:0] base_counter;
  logic [WORD_W-1:0] base_one;
  logic [WORD_W-1:0] base_two;
  logic [WORD_W-1:0] mix_word_next;
  logic [WORD_W-1:0] weyl_counter_next;
  logic [WORD_W-1:0] accum_one_next;
  logic [WORD_W-1:0] accum_two_next;
  logic              pend_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_mix       <= '0;
      seed_counter   <= '0;
      seed_accum_one <= '0;
      seed_accum_two <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SEED_MIX:       seed_mix       <= cfg_data;
        REG_SEED_COUNTER:   seed_counter   <= cfg_data;
        REG_SEED_ACCUM_ONE: seed_accum_one <= cfg_data;
        REG_SEED_ACCUM_TWO: seed_accum_two <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pend_move = pend_valid && (!out_valid || out_ready);
  assign pop       = head.valid && (!pend_valid || pend_move);

  always_comb begin
    base_mix     = head.reload ? seed_mix       : mix_word;
    base_counter = head.reload ? seed_counter   : weyl_counter;
    base_one     = head.reload ? seed_accum_one : accum_one;
    base_two     = head.reload ? seed_accum_two : accum_two;

    mix_word_next     = rotl64(base_mix, ROT_MIX) ^ base_counter;
    weyl_counter_next = base_counter + WEYL_STEP;
    accum_one_next    = rotl64(base_one, ROT_ONE) + mix_word_next;
    accum_two_next    = rotl64(base_two, ROT_TWO) + mix_word_next;
  end

  // Advance the state; it then holds the new words until the mix stage takes them
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_word     <= '0;
      weyl_counter <= '0;
      accum_one    <= '0;
      accum_two    <= '0;
      pend_valid   <= 1'b0;
    end else begin
      if (pop) begin
        mix_word     <= mix_word_next;
        weyl_counter <= weyl_counter_next;
        accum_one    <= accum_one_next;
        accum_two    <= accum_two_next;
        pend_valid   <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pend_one <= base_one;
      pend_two <= base_two;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_word0 <= mix_word + pend_one;
      out_word1 <= (mix_word + weyl_counter) ^ accum_one;
      out_word2 <= mix_word ^ pend_two;
      out_word3 <= mix_word + rotl64(accum_two, ROT_OUT);
    end
  end

endmodule

// ----- hdl/rotate_xor_add_generator_4x64_unit.sv -----
// Rotate-xor-add generator, 4x64: one request in, four 64-bit words out.
// The block takes one request per clock and returns one result per clock
// when the output side keeps up. A request enters a small queue
// (QUEUE_DEPTH entries), the core steps the four-word state from the queue
// head into the state registers, and a mix stage forms the output words from
// the registered state into the output register. The state recurrence in
// the core sets the rate. Seeds are written through the cfg port; the user
// must write them only while the block is idle; the block does not enforce it.
// Seeds reach the state only through a request with reload set.
module rotate_xor_add_generator_4x64_unit
  import rxag_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   reload,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [WORD_W-1:0]      out_word0,
  output logic [WORD_W-1:0]      out_word1,
  output logic [WORD_W-1:0]      out_word2,
  output logic [WORD_W-1:0]      out_word3
);

  rxag_head_t head;
  logic       pop;

  rxag_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .reload   (reload),
    .head     (head),
    .pop      (pop)
  );

  rxag_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word0 (out_word0),
    .out_word1 (out_word1),
    .out_word2 (out_word2),
    .out_word3 (out_word3)
  );

endmodule
